[design/lpvn_pkg.sv]
package lpvn_pkg;

  // Table geometry
  localparam int ATOM_SLOTS = 64;
  localparam int ADDR_W     = $clog2(ATOM_SLOTS);

  // Field widths
  localparam int COORD_W = 24;
  localparam int POS_W   = 3 * COORD_W;
  localparam int TR_W    = 21;
  localparam int CFG_W   = 3 * TR_W;
  localparam int SHIFT_W = 11;
  localparam int CHIR_W  = 3;
  localparam int DIST_W  = 40;
  localparam int UNIT_W  = 16;
  localparam int IN_W    = 128;
  localparam int OUT_W   = 136;

  // Datapath widths
  localparam int PDIFF_W = COORD_W + 1;
  localparam int PROD_W  = 32;
  localparam int D_W     = 36;
  localparam int MAG_W   = 34;
  localparam int HALF_W  = MAG_W / 2;
  localparam int PP_W    = 2 * HALF_W;
  localparam int RAD_W   = 2 * MAG_W;
  localparam int ROOT_W  = MAG_W;
  localparam int REM_W   = ROOT_W + 3;
  localparam int QW      = 15;
  localparam int NUM_W   = ROOT_W + QW + 1;

  localparam logic [QW-1:0] UNIT_ONE = QW'(16384);

  // Item modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_TA = 2'd0;
  localparam logic [1:0] REG_TB = 2'd1;
  localparam logic [1:0] REG_TC = 2'd2;

  // Chirality codes
  localparam logic [CHIR_W-1:0] CHIR_BLOCH     = 3'b001;
  localparam logic [CHIR_W-1:0] CHIR_BLOCH_INV = 3'b111;
  localparam logic [CHIR_W-1:0] CHIR_NEEL      = 3'b010;
  localparam logic [CHIR_W-1:0] CHIR_NEEL_INV  = 3'b110;

  // Offset vector as sign and magnitude, plus chirality
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
    logic [CHIR_W-1:0]     chir;
  } vec_t;

  // One stage of the square root chain
  typedef struct packed {
    logic              valid;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    vec_t              v;
  } sqrt_t;

  // One stage of the three-lane divider chain
  typedef struct packed {
    logic                  valid;
    logic [ROOT_W-1:0]     len;
    logic [NUM_W-1:0]      dsh;
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][QW-1:0]    q;
    logic [2:0]            neg;
    logic [CHIR_W-1:0]     chir;
  } div_t;

endpackage

[design/lattice_pair_vector_and_normal_core.sv]
// Pair offset, distance, unit vector and DMI normal. Mode-0 items load a basis-atom
// position into the table and give no result; mode-1 items give one result each. The
// block takes one item per clock while s_tready is high, and delivers results in order.
// Seven stages form the offset and its squared length, a row of 34 cells extracts the
// square root one bit per cell, a row of 15 cells divides all three components by the
// length one quotient bit per cell, and an output register holds the result. A load may
// be followed directly by an evaluation that reads the new entry. The distance never
// exceeds 34 bits here, so its saturation never engages. Translation registers must be
// written only while idle by the user; the block itself does not enforce this.
module lattice_pair_vector_and_normal_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // mode, first_atom, second_atom, coord_x, coord_y, coord_z,
  // shift_a, shift_b, shift_c, chirality (from bit 0 up)
  input  logic [lpvn_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // distance, unit_x, unit_y, unit_z, dmi_x, dmi_y, dmi_z (from bit 0 up)
  output logic [lpvn_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [lpvn_pkg::CFG_W-1:0] cfg_data
);

  // Input fields
  logic                                 in_mode;
  logic [lpvn_pkg::ADDR_W-1:0]          in_first;
  logic [lpvn_pkg::ADDR_W-1:0]          in_second;
  logic [lpvn_pkg::POS_W-1:0]           in_pos;
  logic signed [lpvn_pkg::SHIFT_W-1:0]  in_shift [3];
  logic [lpvn_pkg::CHIR_W-1:0]          in_chir;

  assign in_mode     = s_tdata[0];
  assign in_first    = s_tdata[6:1];
  assign in_second   = s_tdata[12:7];
  assign in_pos      = s_tdata[84:13];
  assign in_shift[0] = s_tdata[95:85];
  assign in_shift[1] = s_tdata[106:96];
  assign in_shift[2] = s_tdata[117:107];
  assign in_chir     = s_tdata[120:118];

  logic en;
  logic out_en;
  logic accept;

  lpvn_pkg::div_t dv [lpvn_pkg::QW+1];

  // Move the output register when free; move the pipe when its tail can go
  assign out_en   = !m_tvalid || m_tready;
  assign en       = out_en || !dv[lpvn_pkg::QW].valid;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  // Translation registers
  logic [lpvn_pkg::CFG_W-1:0] trans [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      trans[0] <= '0;
      trans[1] <= '0;
      trans[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lpvn_pkg::REG_TA: trans[0] <= cfg_data;
        lpvn_pkg::REG_TB: trans[1] <= cfg_data;
        lpvn_pkg::REG_TC: trans[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Position table, one copy per read address
  logic [lpvn_pkg::POS_W-1:0] pos_a;
  logic [lpvn_pkg::POS_W-1:0] pos_b;
  logic                       tbl_we;

  assign tbl_we = accept && (in_mode == lpvn_pkg::MODE_LOAD);

  lpvn_ram #(.WIDTH(lpvn_pkg::POS_W), .DEPTH(lpvn_pkg::ATOM_SLOTS)) u_tbl_a (
    .clk(clk), .we(tbl_we), .waddr(in_first), .wdata(in_pos),
    .re(accept), .raddr(in_first), .rdata(pos_a)
  );

  lpvn_ram #(.WIDTH(lpvn_pkg::POS_W), .DEPTH(lpvn_pkg::ATOM_SLOTS)) u_tbl_b (
    .clk(clk), .we(tbl_we), .waddr(in_first), .wdata(in_pos),
    .re(accept), .raddr(in_second), .rdata(pos_b)
  );

  // Stage 1: table read, capture shifts
  logic                                s1_valid;
  logic signed [lpvn_pkg::SHIFT_W-1:0] s1_shift [3];
  logic [lpvn_pkg::CHIR_W-1:0]         s1_chir;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_valid <= accept && (in_mode == lpvn_pkg::MODE_EVAL);
      s1_shift <= in_shift;
      s1_chir  <= in_chir;
    end
    if (rst) begin
      s1_valid <= 1'b0;
    end
  end

  // Stage 2: position difference and shift times translation
  logic                                s2_valid;
  logic signed [lpvn_pkg::PDIFF_W-1:0] s2_pdiff [3];
  logic signed [lpvn_pkg::PROD_W-1:0]  s2_prod [3][3];
  logic [lpvn_pkg::CHIR_W-1:0]         s2_chir;
  logic signed [lpvn_pkg::PROD_W-1:0]  sh_x [3];
  logic signed [lpvn_pkg::PROD_W-1:0]  tr_x [3][3];
  logic signed [lpvn_pkg::COORD_W-1:0] pa_c [3];
  logic signed [lpvn_pkg::COORD_W-1:0] pb_c [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sh_x[j] = lpvn_pkg::PROD_W'(s1_shift[j]);
      for (int k = 0; k < 3; k++) begin
        tr_x[j][k] = lpvn_pkg::PROD_W'($signed(trans[j][lpvn_pkg::TR_W*k +: lpvn_pkg::TR_W]));
      end
    end
    for (int k = 0; k < 3; k++) begin
      pa_c[k] = pos_a[lpvn_pkg::COORD_W*k +: lpvn_pkg::COORD_W];
      pb_c[k] = pos_b[lpvn_pkg::COORD_W*k +: lpvn_pkg::COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_valid <= s1_valid;
      s2_chir  <= s1_chir;
      for (int k = 0; k < 3; k++) begin
        s2_pdiff[k] <= lpvn_pkg::PDIFF_W'(pb_c[k]) - lpvn_pkg::PDIFF_W'(pa_c[k]);
        for (int j = 0; j < 3; j++) begin
          s2_prod[k][j] <= sh_x[j] * tr_x[j][k];
        end
      end
    end
    if (rst) begin
      s2_valid <= 1'b0;
    end
  end

  // Stage 3: sum into the offset vector
  logic                            s3_valid;
  logic signed [lpvn_pkg::D_W-1:0] s3_d [3];
  logic [lpvn_pkg::CHIR_W-1:0]     s3_chir;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_valid <= s2_valid;
      s3_chir  <= s2_chir;
      for (int k = 0; k < 3; k++) begin
        s3_d[k] <= lpvn_pkg::D_W'(s2_pdiff[k]) + lpvn_pkg::D_W'(s2_prod[k][0])
                 + lpvn_pkg::D_W'(s2_prod[k][1]) + lpvn_pkg::D_W'(s2_prod[k][2]);
      end
    end
    if (rst) begin
      s3_valid <= 1'b0;
    end
  end

  // Stage 4: sign and magnitude
  logic                  s4_valid;
  lpvn_pkg::vec_t        s4_v;
  logic [lpvn_pkg::D_W-1:0] s3_abs [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s3_abs[k] = s3_d[k][lpvn_pkg::D_W-1] ? -s3_d[k] : s3_d[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_valid   <= s3_valid;
      s4_v.chir  <= s3_chir;
      for (int k = 0; k < 3; k++) begin
        s4_v.neg[k] <= s3_d[k][lpvn_pkg::D_W-1];
        s4_v.mag[k] <= s3_abs[k][lpvn_pkg::MAG_W-1:0];
      end
    end
    if (rst) begin
      s4_valid <= 1'b0;
    end
  end

  // Stage 5: half-word partial products of each square
  logic                          s5_valid;
  lpvn_pkg::vec_t                s5_v;
  logic [lpvn_pkg::PP_W-1:0]     s5_ll [3];
  logic [lpvn_pkg::PP_W-1:0]     s5_lh [3];
  logic [lpvn_pkg::PP_W-1:0]     s5_hh [3];
  logic [lpvn_pkg::PP_W-1:0]     lo_x [3];
  logic [lpvn_pkg::PP_W-1:0]     hi_x [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lo_x[k] = lpvn_pkg::PP_W'(s4_v.mag[k][lpvn_pkg::HALF_W-1:0]);
      hi_x[k] = lpvn_pkg::PP_W'(s4_v.mag[k][lpvn_pkg::MAG_W-1:lpvn_pkg::HALF_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_valid <= s4_valid;
      s5_v     <= s4_v;
      for (int k = 0; k < 3; k++) begin
        s5_ll[k] <= lo_x[k] * lo_x[k];
        s5_lh[k] <= lo_x[k] * hi_x[k];
        s5_hh[k] <= hi_x[k] * hi_x[k];
      end
    end
    if (rst) begin
      s5_valid <= 1'b0;
    end
  end

  // Stage 6: assemble each square
  logic                       s6_valid;
  lpvn_pkg::vec_t             s6_v;
  logic [lpvn_pkg::RAD_W-1:0] s6_sq [3];

  always_ff @(posedge clk) begin
    if (en) begin
      s6_valid <= s5_valid;
      s6_v     <= s5_v;
      for (int k = 0; k < 3; k++) begin
        s6_sq[k] <= (lpvn_pkg::RAD_W'(s5_hh[k]) << (2 * lpvn_pkg::HALF_W))
                  + (lpvn_pkg::RAD_W'(s5_lh[k]) << (lpvn_pkg::HALF_W + 1))
                  + lpvn_pkg::RAD_W'(s5_ll[k]);
      end
    end
    if (rst) begin
      s6_valid <= 1'b0;
    end
  end

  // Stage 7: squared length enters the root chain
  lpvn_pkg::sqrt_t sq [lpvn_pkg::ROOT_W+1];

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].valid <= s6_valid;
      sq[0].rad   <= s6_sq[0] + s6_sq[1] + s6_sq[2];
      sq[0].rem   <= '0;
      sq[0].root  <= '0;
      sq[0].v     <= s6_v;
    end
    if (rst) begin
      sq[0].valid <= 1'b0;
    end
  end

  // Root chain: one bit per cell
  for (genvar i = 0; i < lpvn_pkg::ROOT_W; i++) begin : g_sqrt
    lpvn_sqrt_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .din(sq[i]), .dout(sq[i+1])
    );
  end

  // Divider chain input: numerator a*2^15 + len over divisor 2*len
  logic [lpvn_pkg::ROOT_W-1:0] root_fin;

  assign root_fin = sq[lpvn_pkg::ROOT_W].root;

  always_comb begin
    dv[0].valid = sq[lpvn_pkg::ROOT_W].valid;
    dv[0].len   = root_fin;
    dv[0].dsh   = lpvn_pkg::NUM_W'({root_fin, 1'b0}) << (lpvn_pkg::QW - 1);
    dv[0].neg   = sq[lpvn_pkg::ROOT_W].v.neg;
    dv[0].chir  = sq[lpvn_pkg::ROOT_W].v.chir;
    for (int k = 0; k < 3; k++) begin
      dv[0].rem[k] = (lpvn_pkg::NUM_W'(sq[lpvn_pkg::ROOT_W].v.mag[k]) << lpvn_pkg::QW)
                   + lpvn_pkg::NUM_W'(root_fin);
      dv[0].q[k]   = '0;
    end
  end

  // Divider chain: one quotient bit per cell
  for (genvar i = 0; i < lpvn_pkg::QW; i++) begin : g_div
    lpvn_div_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .din(dv[i]), .dout(dv[i+1])
    );
  end

  // Clamp, sign, pick the normal
  logic signed [lpvn_pkg::UNIT_W-1:0] u [3];
  logic signed [lpvn_pkg::UNIT_W-1:0] n [3];
  logic [lpvn_pkg::QW-1:0]            qc;
  lpvn_pkg::div_t                     fin;

  assign fin = dv[lpvn_pkg::QW];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qc = (fin.q[k] > lpvn_pkg::UNIT_ONE) ? lpvn_pkg::UNIT_ONE : fin.q[k];
      if (fin.len == '0) begin
        u[k] = '0;
      end else if (fin.neg[k]) begin
        u[k] = -lpvn_pkg::UNIT_W'(qc);
      end else begin
        u[k] = lpvn_pkg::UNIT_W'(qc);
      end
    end
    case (fin.chir)
      lpvn_pkg::CHIR_BLOCH: begin
        n[0] = u[0];  n[1] = u[1];  n[2] = u[2];
      end
      lpvn_pkg::CHIR_BLOCH_INV: begin
        n[0] = -u[0]; n[1] = -u[1]; n[2] = -u[2];
      end
      lpvn_pkg::CHIR_NEEL: begin
        n[0] = u[1];  n[1] = -u[0]; n[2] = '0;
      end
      lpvn_pkg::CHIR_NEEL_INV: begin
        n[0] = -u[1]; n[1] = u[0];  n[2] = '0;
      end
      default: begin
        n[0] = '0;    n[1] = '0;    n[2] = '0;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_en) begin
      m_tvalid <= fin.valid;
      m_tdata  <= {n[2], n[1], n[0], u[2], u[1], u[0],
                   lpvn_pkg::DIST_W'(fin.len)};
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

[design/lpvn_ram.sv]
module lpvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/lpvn_sqrt_cell.sv]
module lpvn_sqrt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  lpvn_pkg::sqrt_t din,
  output lpvn_pkg::sqrt_t dout
);

  logic [lpvn_pkg::REM_W-1:0] rem_sh;
  logic [lpvn_pkg::REM_W-1:0] trial;
  logic                       ge;
  lpvn_pkg::sqrt_t            nxt;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rem_sh = {din.rem[lpvn_pkg::REM_W-3:0], din.rad[lpvn_pkg::RAD_W-1 -: 2]};
    trial  = {1'b0, din.root, 2'b01};
    ge     = rem_sh >= trial;
    nxt       = din;
    nxt.rad   = {din.rad[lpvn_pkg::RAD_W-3:0], 2'b00};
    nxt.rem   = ge ? rem_sh - trial : rem_sh;
    nxt.root  = {din.root[lpvn_pkg::ROOT_W-2:0], ge};
  end

  // Hand the partial root to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end
  end

endmodule

[design/lpvn_div_cell.sv]
module lpvn_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  lpvn_pkg::div_t din,
  output lpvn_pkg::div_t dout
);

  logic [2:0]     ge;
  lpvn_pkg::div_t nxt;

  // Subtract the aligned divisor in each lane, then move it one bit down
  always_comb begin
    nxt     = din;
    nxt.dsh = din.dsh >> 1;
    for (int k = 0; k < 3; k++) begin
      ge[k]      = din.rem[k] >= din.dsh;
      nxt.rem[k] = ge[k] ? din.rem[k] - din.dsh : din.rem[k];
      nxt.q[k]   = {din.q[k][lpvn_pkg::QW-2:0], ge[k]};
    end
  end

  // Hand the partial quotients to the next cell
  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
    if (rst) begin
      dout.valid <= 1'b0;
    end
  end

endmodule

[design/lpvn_checker.sv]
module lpvn_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [lpvn_pkg::OUT_W-1:0] m_tdata
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Zero distance gives zero unit and normal
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:0] == 40'd0) |-> (m_tdata[135:40] == 96'd0))
    else $error("nonzero vector for zero distance");

  // Unit components stay within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[55:40]) <= 16'sd16384)
              && ($signed(m_tdata[55:40]) >= -16'sd16384)
              && ($signed(m_tdata[71:56]) <= 16'sd16384)
              && ($signed(m_tdata[71:56]) >= -16'sd16384)
              && ($signed(m_tdata[87:72]) <= 16'sd16384)
              && ($signed(m_tdata[87:72]) >= -16'sd16384))
    else $error("unit component out of range");

endmodule

bind lattice_pair_vector_and_normal_core lpvn_checker u_lpvn_checker (
  .clk(clk), .rst(rst), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

[sim/tb_lattice_pair_vector_and_normal_core.sv]
`timescale 1ns / 100ps

module tb_lattice_pair_vector_and_normal_core;

  localparam int HALF_PERIOD = 4;
  localparam int DRAIN_CYCLES = 90;
  localparam int STALL_LIMIT = 5000;

  typedef struct {
    logic                                mode;
    logic [lpvn_pkg::ADDR_W-1:0]         src;
    logic [lpvn_pkg::ADDR_W-1:0]         dst;
    logic signed [lpvn_pkg::COORD_W-1:0] px, py, pz;
    logic signed [lpvn_pkg::SHIFT_W-1:0] sa, sb, sc;
    logic [lpvn_pkg::CHIR_W-1:0]         chir;
  } pair_item_t;

  typedef struct packed {
    logic [lpvn_pkg::DIST_W-1:0] len;
    logic [lpvn_pkg::UNIT_W-1:0] ux, uy, uz, nx, ny, nz;
  } pair_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [lpvn_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [lpvn_pkg::OUT_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = lpvn_pkg::REG_TA;
  logic [lpvn_pkg::CFG_W-1:0] cfg_data = '0;

  // predictor state
  logic signed [lpvn_pkg::COORD_W-1:0] atom_x [lpvn_pkg::ATOM_SLOTS];
  logic signed [lpvn_pkg::COORD_W-1:0] atom_y [lpvn_pkg::ATOM_SLOTS];
  logic signed [lpvn_pkg::COORD_W-1:0] atom_z [lpvn_pkg::ATOM_SLOTS];
  logic [lpvn_pkg::CFG_W-1:0] trans [3];
  int loaded_slots [$];

  pair_result_t pending_results [$];
  int mismatches = 0;
  int quiet_cycles = 0;
  bit no_idle = 1'b0;

  lattice_pair_vector_and_normal_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Rounded Q1.14 component of the offset, clamped at one
  function automatic logic [lpvn_pkg::UNIT_W-1:0] unit_component(longint d,
                                                                 longint unsigned len);
    longint unsigned a;
    longint unsigned q;
    a = (d < 0) ? longint'(-d) : longint'(d);
    q = (a * 64'd32768 + len) / (64'd2 * len);
    if (q > 64'd16384) q = 64'd16384;
    return (d < 0) ? lpvn_pkg::UNIT_W'(-longint'(q)) : lpvn_pkg::UNIT_W'(q);
  endfunction

  // Offset, length, unit vector and DMI normal of one pair
  function automatic pair_result_t pair_geometry(pair_item_t it);
    pair_result_t r;
    longint d [3];
    longint unsigned a;
    logic [71:0] aa;
    logic [71:0] sumsq;
    logic [73:0] sq;
    logic [36:0] root;
    logic [36:0] trial;
    logic signed [lpvn_pkg::TR_W-1:0] ta, tb, tc;
    logic signed [lpvn_pkg::COORD_W-1:0] pa, pb;
    logic [lpvn_pkg::UNIT_W-1:0] u [3];
    sumsq = '0;
    for (int k = 0; k < 3; k++) begin
      pa = (k == 0) ? atom_x[it.src] : (k == 1) ? atom_y[it.src] : atom_z[it.src];
      pb = (k == 0) ? atom_x[it.dst] : (k == 1) ? atom_y[it.dst] : atom_z[it.dst];
      ta = trans[0][lpvn_pkg::TR_W*k +: lpvn_pkg::TR_W];
      tb = trans[1][lpvn_pkg::TR_W*k +: lpvn_pkg::TR_W];
      tc = trans[2][lpvn_pkg::TR_W*k +: lpvn_pkg::TR_W];
      d[k] = longint'(pb) - longint'(pa) + longint'(it.sa) * longint'(ta)
           + longint'(it.sb) * longint'(tb) + longint'(it.sc) * longint'(tc);
      a = (d[k] < 0) ? longint'(-d[k]) : longint'(d[k]);
      aa = 72'(a);
      sumsq = sumsq + aa * aa;
    end
    root = '0;
    for (int b = 36; b >= 0; b--) begin
      trial = root | (37'd1 << b);
      sq = 74'(trial) * 74'(trial);
      if (sq <= 74'(sumsq)) root = trial;
    end
    r = '{default: '0};
    r.len = ({3'b000, root} > 40'hFF_FFFF_FFFF) ? '1 : lpvn_pkg::DIST_W'(root);
    if (root != 0) begin
      for (int k = 0; k < 3; k++) u[k] = unit_component(d[k], 64'(root));
      r.ux = u[0]; r.uy = u[1]; r.uz = u[2];
      case (it.chir)
        lpvn_pkg::CHIR_BLOCH:     begin r.nx = u[0];  r.ny = u[1];  r.nz = u[2];  end
        lpvn_pkg::CHIR_BLOCH_INV: begin r.nx = -u[0]; r.ny = -u[1]; r.nz = -u[2]; end
        lpvn_pkg::CHIR_NEEL:      begin r.nx = u[1];  r.ny = -u[0]; end
        lpvn_pkg::CHIR_NEEL_INV:  begin r.nx = -u[1]; r.ny = u[0];  end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Drive one item, hold it until the transfer, then update the predictor
  task automatic send_item(pair_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= lpvn_pkg::IN_W'({it.chir, it.sc, it.sb, it.sa, it.pz, it.py, it.px,
                                it.dst, it.src, it.mode});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (it.mode == lpvn_pkg::MODE_LOAD) begin
      atom_x[it.src] = it.px;
      atom_y[it.src] = it.py;
      atom_z[it.src] = it.pz;
      if (!(it.src inside {loaded_slots})) loaded_slots = {loaded_slots, int'(it.src)};
    end else begin
      pending_results = {pending_results, pair_geometry(it)};
    end
    @(negedge clk);
  endtask

  // Wait out every pending result plus the pipeline depth
  task automatic drain_pipeline();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_translation(logic [1:0] idx, logic [lpvn_pkg::CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    trans[idx] = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic pair_item_t load_item(int slot, logic [lpvn_pkg::COORD_W-1:0] x,
                                           logic [lpvn_pkg::COORD_W-1:0] y,
                                           logic [lpvn_pkg::COORD_W-1:0] z);
    pair_item_t it;
    it = '{default: '0};
    it.mode = lpvn_pkg::MODE_LOAD;
    it.src = lpvn_pkg::ADDR_W'(slot);
    it.dst = lpvn_pkg::ADDR_W'($urandom);
    it.px = x; it.py = y; it.pz = z;
    it.sa = lpvn_pkg::SHIFT_W'($urandom);
    it.sb = lpvn_pkg::SHIFT_W'($urandom);
    it.sc = lpvn_pkg::SHIFT_W'($urandom);
    it.chir = lpvn_pkg::CHIR_W'($urandom);
    return it;
  endfunction

  function automatic pair_item_t eval_item(int src, int dst, int sa, int sb, int sc,
                                           logic [lpvn_pkg::CHIR_W-1:0] chir);
    pair_item_t it;
    it.mode = lpvn_pkg::MODE_EVAL;
    it.src = lpvn_pkg::ADDR_W'(src);
    it.dst = lpvn_pkg::ADDR_W'(dst);
    it.px = lpvn_pkg::COORD_W'($urandom);
    it.py = lpvn_pkg::COORD_W'($urandom);
    it.pz = lpvn_pkg::COORD_W'($urandom);
    it.sa = lpvn_pkg::SHIFT_W'(sa);
    it.sb = lpvn_pkg::SHIFT_W'(sb);
    it.sc = lpvn_pkg::SHIFT_W'(sc);
    it.chir = chir;
    return it;
  endfunction

  function automatic int any_loaded();
    return loaded_slots[$urandom_range(0, loaded_slots.size() - 1)];
  endfunction

  function automatic logic [lpvn_pkg::CFG_W-1:0] random_translation(int span);
    logic [lpvn_pkg::CFG_W-1:0] v;
    for (int k = 0; k < 3; k++)
      v[lpvn_pkg::TR_W*k +: lpvn_pkg::TR_W] =
        lpvn_pkg::TR_W'($urandom_range(0, 2 * span) - span);
    return v;
  endfunction

  // Coordinate extremes in both end slots, pairs across them
  task automatic test_extremes();
    no_idle = 1'b1;
    send_item(load_item(0, 24'h7FFFFF, 24'h800000, 24'h000000));
    send_item(load_item(lpvn_pkg::ATOM_SLOTS - 1, 24'h800000, 24'h7FFFFF, 24'hFFFFFF));
    send_item(eval_item(0, lpvn_pkg::ATOM_SLOTS - 1, 0, 0, 0, lpvn_pkg::CHIR_BLOCH));
    send_item(eval_item(lpvn_pkg::ATOM_SLOTS - 1, 0, 1023, -1023, 1023,
                        lpvn_pkg::CHIR_NEEL));
    send_item(eval_item(0, lpvn_pkg::ATOM_SLOTS - 1, -1024, -1024, -1024,
                        lpvn_pkg::CHIR_BLOCH_INV));
    send_item(load_item(5, 24'h000001, 24'h000000, 24'h7FFFFF));
    send_item(eval_item(5, 0, 1, 0, -1, lpvn_pkg::CHIR_NEEL_INV));
    no_idle = 1'b0;
  endtask

  // Each chirality code, including the ones with no normal
  task automatic test_chirality();
    send_item(load_item(7, 24'h001000, 24'h002000, 24'hFFE000));
    for (int c = 0; c < 8; c++)
      send_item(eval_item(0, 7, 0, 0, 0, lpvn_pkg::CHIR_W'(c)));
  endtask

  // Same atom with no shift, and two atoms at the same position
  task automatic test_zero_offset();
    send_item(eval_item(7, 7, 0, 0, 0, lpvn_pkg::CHIR_BLOCH));
    send_item(eval_item(0, 0, 0, 0, 0, lpvn_pkg::CHIR_NEEL));
    send_item(load_item(9, 24'h001000, 24'h002000, 24'hFFE000));
    send_item(eval_item(7, 9, 0, 0, 0, lpvn_pkg::CHIR_NEEL_INV));
  endtask

  // Mostly evaluations over loaded atoms, with reloads mixed in
  task automatic test_random_pairs(int count);
    pair_item_t it;
    int shift_span;
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        send_item(load_item($urandom_range(0, lpvn_pkg::ATOM_SLOTS - 1),
                            lpvn_pkg::COORD_W'($urandom), lpvn_pkg::COORD_W'($urandom),
                            lpvn_pkg::COORD_W'($urandom)));
      end else begin
        shift_span = ($urandom_range(0, 1) == 0) ? 3 : 1024;
        it = eval_item(any_loaded(), any_loaded(),
                       $urandom_range(0, 2 * shift_span) - shift_span,
                       $urandom_range(0, 2 * shift_span) - shift_span,
                       $urandom_range(0, 2 * shift_span) - shift_span,
                       lpvn_pkg::CHIR_W'($urandom));
        if ($urandom_range(0, 15) == 0) it.sa = lpvn_pkg::SHIFT_W'($urandom);
        send_item(it);
      end
    end
    no_idle = 1'b0;
  endtask

  // Sweep translation settings between idle phases
  task automatic test_translations();
    drain_pipeline();
    write_translation(lpvn_pkg::REG_TA, {3{21'h0FFFFF}});
    write_translation(lpvn_pkg::REG_TB, {3{21'h100000}});
    write_translation(lpvn_pkg::REG_TC, '1);
    test_random_pairs(150);
    drain_pipeline();
    write_translation(lpvn_pkg::REG_TA, {21'h000000, 21'h000000, 21'h001000});
    write_translation(lpvn_pkg::REG_TB, {21'h000000, 21'h001000, 21'h000000});
    write_translation(lpvn_pkg::REG_TC, {21'h001000, 21'h000000, 21'h000000});
    test_random_pairs(300);
    for (int p = 0; p < 4; p++) begin
      drain_pipeline();
      write_translation(lpvn_pkg::REG_TA,
                        ($urandom_range(0, 1) == 0) ? random_translation(20000)
                                                    : lpvn_pkg::CFG_W'({$urandom, $urandom}));
      write_translation(lpvn_pkg::REG_TB, random_translation(1 << 20 - 1));
      write_translation(lpvn_pkg::REG_TC, random_translation(4096));
      test_random_pairs(170);
    end
    drain_pipeline();
    write_translation(lpvn_pkg::REG_TA, '0);
    write_translation(lpvn_pkg::REG_TB, '0);
    write_translation(lpvn_pkg::REG_TC, '0);
    test_random_pairs(100);
  endtask

  // Random backpressure on the result side
  initial begin
    int stall;
    forever begin
      @(negedge clk);
      stall = no_idle ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    pair_result_t want;
    pair_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.len = m_tdata[39:0];
      got.ux = m_tdata[55:40];
      got.uy = m_tdata[71:56];
      got.uz = m_tdata[87:72];
      got.nx = m_tdata[103:88];
      got.ny = m_tdata[119:104];
      got.nz = m_tdata[135:120];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer: %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch: dist %h/%h unit %h %h %h/%h %h %h dmi %h %h %h/%h %h %h",
                     want.len, got.len, want.ux, want.uy, want.uz, got.ux, got.uy, got.uz,
                     want.nx, want.ny, want.nz, got.nx, got.ny, got.nz);
        end
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst ||
        pending_results.size() == 0 && !s_tvalid)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    trans[0] = '0; trans[1] = '0; trans[2] = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_extremes();
    test_chirality();
    test_zero_offset();
    test_random_pairs(200);
    test_translations();
    drain_pipeline();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
design/lpvn_pkg.sv
design/lpvn_ram.sv
design/lpvn_sqrt_cell.sv
design/lpvn_div_cell.sv
design/lattice_pair_vector_and_normal_core.sv
design/lpvn_checker.sv
sim/tb_lattice_pair_vector_and_normal_core.sv
